FILE: sv/dfs_pkg.sv
// Shared types and constants of the delimiter field splitter.
`default_nettype none
package dfs_pkg;

	localparam int CFG_DATA_W  = 64;
	localparam int CFG_INDEX_W = 2;
	localparam int LEN_W       = 4;
	localparam int OUT_W       = 16;

	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_TAB   = 8'h09;

	localparam logic STATUS_FIELD    = 1'b0;
	localparam logic STATUS_NO_MATCH = 1'b1;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_DELIM_BYTES  = 2'd0,
		CFG_DELIM_LENGTH = 2'd1,
		CFG_TRIM_ENABLE  = 2'd2
	} cfg_index_t;

	typedef struct packed {
		logic [CFG_DATA_W-1:0] delimiter_bytes;
		logic [LEN_W-1:0]      delimiter_length;
		logic                  trim_enable;
	} cfg_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

endpackage
`default_nettype wire

FILE: sv/dfs_channels.sv
// Valid/ready channel interfaces for input bytes and field results.
`default_nettype none
interface dfs_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface dfs_out_if;
	logic                       valid;
	logic                       ready;
	logic                       status;
	logic [dfs_pkg::OUT_W-1:0]  field_start;
	logic [dfs_pkg::OUT_W-1:0]  field_length;

	modport source (output valid, output status, output field_start, output field_length,
		input ready);
	modport sink (input valid, input status, input field_start, input field_length,
		output ready);
endinterface
`default_nettype wire

FILE: sv/dfs_cfg.sv
// Configuration registers: delimiter bytes, delimiter length and trim enable.
`default_nettype none
module dfs_cfg (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             we,
	input  wire logic [dfs_pkg::CFG_INDEX_W-1:0]  index,
	input  wire logic [dfs_pkg::CFG_DATA_W-1:0]   data,
	output dfs_pkg::cfg_t                         cfg
);

	dfs_pkg::cfg_t cfg_q;

	// Write the addressed register; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.delimiter_bytes  <= dfs_pkg::CFG_DATA_W'(44);
			cfg_q.delimiter_length <= dfs_pkg::LEN_W'(1);
			cfg_q.trim_enable      <= 1'b0;
		end else if (we) begin
			case (dfs_pkg::cfg_index_t'(index))
				dfs_pkg::CFG_DELIM_BYTES: begin
					cfg_q.delimiter_bytes <= data;
				end
				dfs_pkg::CFG_DELIM_LENGTH: begin
					cfg_q.delimiter_length <= data[dfs_pkg::LEN_W-1:0];
				end
				dfs_pkg::CFG_TRIM_ENABLE: begin
					cfg_q.trim_enable <= data[0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

FILE: sv/dfs_core.sv
// Field state, delimiter window compare, trimming record and result register.
`default_nettype none
module dfs_core #(
	parameter int MAX_DELIM   = 8,
	parameter int OFFSET_BITS = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              advance,
	input  wire dfs_pkg::in_item_t item,
	input  wire dfs_pkg::cfg_t     cfg,
	output logic                   out_free,
	dfs_out_if.source              res
);

	localparam int BW = $clog2(MAX_DELIM + 1);
	localparam int LW = dfs_pkg::LEN_W;
	localparam int OW = dfs_pkg::OUT_W;

	logic [OFFSET_BITS-1:0] pos_q, cfs_q, first_q, lastnb_q;
	logic [7:0]             win_q [MAX_DELIM];
	logic                   blank_q [MAX_DELIM];
	logic [BW-1:0]          bif_q;
	logic                   seen_q;

	logic                   res_valid_q;
	logic                   res_status_q;
	logic [OW-1:0]          res_start_q, res_length_q;

	logic [LW-1:0]          len;
	logic [OFFSET_BITS-1:0] p_next, fld_end, aged_pos, first_n, lastnb_n;
	logic [OFFSET_BITS-1:0] s_val, l_val;
	logic [OFFSET_BITS+OW-1:0] s_ext, l_ext;
	logic [7:0]             win_n [MAX_DELIM];
	logic                   blank_n [MAX_DELIM];
	logic [BW-1:0]          bif_n;
	logic                   seen_n;
	logic                   blank_old;
	logic                   match;
	logic [LW-1:0]          k;

	// Clamp length, age the oldest candidate byte, shift the window, compare, form the result
	always_comb begin
		if (cfg.delimiter_length == '0) begin
			len = LW'(1);
		end else if (cfg.delimiter_length > LW'(MAX_DELIM)) begin
			len = LW'(MAX_DELIM);
		end else begin
			len = cfg.delimiter_length;
		end

		p_next   = pos_q + OFFSET_BITS'(1);
		fld_end  = p_next - OFFSET_BITS'(len);
		aged_pos = pos_q - OFFSET_BITS'(len);

		blank_old = 1'b0;
		for (int i = 0; i < MAX_DELIM; i++) begin
			if (LW'(i) == len - LW'(1)) begin
				blank_old = blank_q[i];
			end
		end

		seen_n   = seen_q;
		first_n  = first_q;
		lastnb_n = lastnb_q;
		if (LW'(bif_q) >= len && !blank_old) begin
			if (!seen_q) begin
				first_n = aged_pos;
				seen_n  = 1'b1;
			end
			lastnb_n = aged_pos;
		end

		win_n[0]   = item.data_byte;
		blank_n[0] = (item.data_byte == dfs_pkg::CHAR_SPACE) ||
			(item.data_byte == dfs_pkg::CHAR_TAB);
		for (int i = 1; i < MAX_DELIM; i++) begin
			win_n[i]   = win_q[i-1];
			blank_n[i] = blank_q[i-1];
		end

		bif_n = (bif_q < BW'(MAX_DELIM)) ? bif_q + BW'(1) : bif_q;

		match = (LW'(bif_n) >= len);
		for (int i = 0; i < MAX_DELIM; i++) begin
			k = len - LW'(1) - LW'(i);
			if (LW'(i) < len &&
				win_n[i] != 8'(cfg.delimiter_bytes >> {k, 3'b000})) begin
				match = 1'b0;
			end
		end

		if (cfg.trim_enable) begin
			if (seen_n) begin
				s_val = first_n;
				l_val = lastnb_n - first_n + OFFSET_BITS'(1);
			end else begin
				s_val = fld_end;
				l_val = '0;
			end
		end else begin
			s_val = cfs_q;
			l_val = fld_end - cfs_q;
		end
		s_ext = {{OW{1'b0}}, s_val};
		l_ext = {{OW{1'b0}}, l_val};
	end

	// Update field state per request; the final byte clears everything
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			cfs_q    <= '0;
			first_q  <= '0;
			lastnb_q <= '0;
			bif_q    <= '0;
			seen_q   <= 1'b0;
			for (int i = 0; i < MAX_DELIM; i++) begin
				win_q[i]   <= '0;
				blank_q[i] <= 1'b0;
			end
		end else if (advance) begin
			if (item.last_byte) begin
				pos_q    <= '0;
				cfs_q    <= '0;
				first_q  <= '0;
				lastnb_q <= '0;
				bif_q    <= '0;
				seen_q   <= 1'b0;
				for (int i = 0; i < MAX_DELIM; i++) begin
					win_q[i]   <= '0;
					blank_q[i] <= 1'b0;
				end
			end else begin
				pos_q <= p_next;
				for (int i = 0; i < MAX_DELIM; i++) begin
					win_q[i]   <= win_n[i];
					blank_q[i] <= blank_n[i];
				end
				if (match) begin
					cfs_q    <= p_next;
					bif_q    <= '0;
					seen_q   <= 1'b0;
					first_q  <= '0;
					lastnb_q <= '0;
				end else begin
					bif_q    <= bif_n;
					seen_q   <= seen_n;
					first_q  <= first_n;
					lastnb_q <= lastnb_n;
				end
			end
		end
	end

	// Hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && (match || item.last_byte)) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// Load the result payload
	always_ff @(posedge clk) begin
		if (advance && match) begin
			res_status_q <= dfs_pkg::STATUS_FIELD;
			res_start_q  <= s_ext[OW-1:0];
			res_length_q <= l_ext[OW-1:0];
		end else if (advance && item.last_byte) begin
			res_status_q <= dfs_pkg::STATUS_NO_MATCH;
			res_start_q  <= '0;
			res_length_q <= '0;
		end
	end

	assign out_free         = !res_valid_q || res.ready;
	assign res.valid        = res_valid_q;
	assign res.status       = res_status_q;
	assign res.field_start  = res_start_q;
	assign res.field_length = res_length_q;

`ifndef SYNTHESIS
	a_bif_range: assert property (@(posedge clk) disable iff (!arst_n)
		bif_q <= BW'(MAX_DELIM))
		else $error("field byte count beyond window depth");

	a_buffer_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item.last_byte |=> pos_q == '0 && !seen_q && bif_q == '0)
		else $error("state not cleared after final byte");

	a_no_match_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_status_q == dfs_pkg::STATUS_NO_MATCH |->
			res_start_q == '0 && res_length_q == '0)
		else $error("no-match result carries nonzero fields");
`endif

endmodule
`default_nettype wire

FILE: sv/delimiter_field_splitter_top.sv
// Top level of the delimiter field splitter: input stage, config and core.
//
//  channel    dir  handshake            payload
//  byte_in    in   valid/ready          data_byte[7:0], last_byte
//  field_out  out  valid/ready          status, field_start[15:0], field_length[15:0]
//  cfg        in   cfg_we (no ready)    cfg_index[1:0], cfg_data[63:0]
//
// One byte per cycle sustained while the result register is free or being taken; a byte
// waits in the input register, and its result, if any, is loaded into the result register
// as the byte moves into the core. Throughput is set by the combinational window compare and field update.
// Reset (arst_n low) clears all field state and loads the register defaults.
// A stalled result register holds the input register, which then drops ready.
`default_nettype none
module delimiter_field_splitter_top #(
	parameter int MAX_DELIM   = 8,
	parameter int OFFSET_BITS = 16
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	dfs_in_if.sink                                byte_in,
	dfs_out_if.source                             field_out,
	input  wire logic                             cfg_we,
	input  wire logic [dfs_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  wire logic [dfs_pkg::CFG_DATA_W-1:0]   cfg_data
);

	dfs_pkg::cfg_t     cfg;
	dfs_pkg::in_item_t item_s1;
	logic              valid_s1;
	logic              out_free;
	logic              advance;

	dfs_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	// Move the staged request into the core when the result slot is free
	assign advance       = valid_s1 && out_free;
	assign byte_in.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_in.valid && byte_in.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Capture the request payload
	always_ff @(posedge clk) begin
		if (byte_in.valid && byte_in.ready) begin
			item_s1.data_byte <= byte_in.data_byte;
			item_s1.last_byte <= byte_in.last_byte;
		end
	end

	dfs_core #(
		.MAX_DELIM   (MAX_DELIM),
		.OFFSET_BITS (OFFSET_BITS)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.item     (item_s1),
		.cfg      (cfg),
		.out_free (out_free),
		.res      (field_out)
	);

`ifndef SYNTHESIS
	a_accept_fills_stage: assert property (@(posedge clk) disable iff (!arst_n)
		byte_in.valid && byte_in.ready |=> valid_s1)
		else $error("accepted request not staged");

	a_stall_keeps_stage: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(item_s1))
		else $error("staged request lost while stalled");

	a_empty_stage_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> byte_in.ready)
		else $error("empty input stage refuses requests");
`endif

endmodule
`default_nettype wire

FILE: sim/delimiter_field_splitter_checker.sv
// Checker for the delimiter field splitter: predicts field results and compares them.
module delimiter_field_splitter_checker
	import dfs_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	dfs_in_if                      byte_in,
	dfs_out_if                     field_out,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output int                     pending_results,
	output int                     fail_count
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_DELIM = 8;
	localparam int POS_W     = 16;

	typedef struct {
		logic             status;
		logic [OUT_W-1:0] field_start;
		logic [OUT_W-1:0] field_length;
	} field_result_t;

	field_result_t expected_fields[$];

	// Mirror of the register file
	cfg_t cfg;

	// Mirror of the field state
	logic [POS_W-1:0] next_pos;
	logic [POS_W-1:0] field_base;
	logic [POS_W-1:0] first_kept;
	logic [POS_W-1:0] last_kept;
	logic             kept_seen;
	logic [7:0]       recent_bytes [MAX_DELIM];
	logic             recent_blank [MAX_DELIM];
	int unsigned      field_fill;

	initial begin
		fail_count      = 0;
		pending_results = 0;
	end

	task automatic report_mismatch(input string msg);
		$display("%0t ns: mismatch: %s", $realtime, msg);
		fail_count++;
	endtask

	task automatic clear_buffer_state();
		int unsigned i;
		next_pos   = '0;
		field_base = '0;
		first_kept = '0;
		last_kept  = '0;
		kept_seen  = 1'b0;
		field_fill = 0;
		for (i = 0; i < MAX_DELIM; i++) begin
			recent_bytes[i] = '0;
			recent_blank[i] = 1'b0;
		end
	endtask

	// Advance the field state by one byte and queue the result it causes
	task automatic split_byte(input logic [7:0] b, input logic last);
		int unsigned   len;
		int unsigned   i;
		logic [15:0]   aged_pos;
		logic [15:0]   delim_end;
		logic          hit;
		field_result_t r;

		if (cfg.delimiter_length == 0)
			len = 1;
		else if (cfg.delimiter_length > MAX_DELIM)
			len = MAX_DELIM;
		else
			len = cfg.delimiter_length;

		// The byte len back can no longer belong to a delimiter: record it for trimming
		if (field_fill >= len) begin
			aged_pos = next_pos - 16'(len);
			if (!recent_blank[len-1]) begin
				if (!kept_seen) begin
					first_kept = aged_pos;
					kept_seen  = 1'b1;
				end
				last_kept = aged_pos;
			end
		end

		// Shift the new byte into the window
		for (i = MAX_DELIM - 1; i > 0; i--) begin
			recent_bytes[i] = recent_bytes[i-1];
			recent_blank[i] = recent_blank[i-1];
		end
		recent_bytes[0] = b;
		recent_blank[0] = (b == CHAR_SPACE) || (b == CHAR_TAB);
		if (field_fill < MAX_DELIM)
			field_fill++;

		// Delimiter bytes must all lie inside the current field
		hit = (field_fill >= len);
		for (i = 0; i < len; i++) begin
			if (recent_bytes[i] != cfg.delimiter_bytes[8*(len-1-i) +: 8])
				hit = 1'b0;
		end

		if (hit) begin
			delim_end = next_pos + 16'd1 - 16'(len);
			r.status  = STATUS_FIELD;
			if (cfg.trim_enable) begin
				if (kept_seen) begin
					r.field_start  = first_kept;
					r.field_length = last_kept - first_kept + 16'd1;
				end else begin
					r.field_start  = delim_end;
					r.field_length = '0;
				end
			end else begin
				r.field_start  = field_base;
				r.field_length = delim_end - field_base;
			end
			expected_fields.push_back(r);
			field_base = next_pos + 16'd1;
			field_fill = 0;
			kept_seen  = 1'b0;
			first_kept = '0;
			last_kept  = '0;
		end else if (last) begin
			r.status       = STATUS_NO_MATCH;
			r.field_start  = '0;
			r.field_length = '0;
			expected_fields.push_back(r);
		end

		next_pos = next_pos + 16'd1;
		if (last)
			clear_buffer_state();
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		field_result_t want;
		if (!arst_n) begin
			cfg.delimiter_bytes  = 64'd44;
			cfg.delimiter_length = 4'd1;
			cfg.trim_enable      = 1'b0;
			clear_buffer_state();
			expected_fields.delete();
			pending_results <= 0;
		end else begin
			// Compare each delivered result with the oldest prediction
			if (field_out.valid && field_out.ready) begin
				if (expected_fields.size() == 0) begin
					report_mismatch($sformatf("unexpected result status %0d start %0d length %0d",
						field_out.status, field_out.field_start, field_out.field_length));
				end else begin
					want = expected_fields.pop_front();
					if (field_out.status !== want.status)
						report_mismatch($sformatf("status got %0d want %0d",
							field_out.status, want.status));
					if (field_out.field_start !== want.field_start)
						report_mismatch($sformatf("field_start got %0d want %0d",
							field_out.field_start, want.field_start));
					if (field_out.field_length !== want.field_length)
						report_mismatch($sformatf("field_length got %0d want %0d",
							field_out.field_length, want.field_length));
				end
			end

			// Track register writes
			if (cfg_we) begin
				case (cfg_index_t'(cfg_index))
					CFG_DELIM_BYTES:  cfg.delimiter_bytes  = cfg_data;
					CFG_DELIM_LENGTH: cfg.delimiter_length = cfg_data[LEN_W-1:0];
					CFG_TRIM_ENABLE:  cfg.trim_enable      = cfg_data[0];
					default: ;
				endcase
			end

			if (byte_in.valid && byte_in.ready)
				split_byte(byte_in.data_byte, byte_in.last_byte);

			pending_results <= expected_fields.size();
		end
	end

endmodule

FILE: sim/delimiter_field_splitter_top_tb.sv
// Testbench top of the delimiter field splitter: stimulus, flow control and verdict.
module delimiter_field_splitter_top_tb
	import dfs_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          LONG_HOLD_CYCLES = 64;
	localparam int          PHASE_BYTES      = 225;
	localparam int          RANDOM_PHASES    = 8;
	localparam int          DRAIN_CYCLES     = 4;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	int                     pending_results;
	int                     fail_count;

	dfs_in_if  byte_in();
	dfs_out_if field_out();

	in_item_t    stim_q[$];
	logic        no_gaps;
	logic        long_hold_req;
	logic [63:0] cur_delim;
	int unsigned cur_len;

	delimiter_field_splitter_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_in   (byte_in),
		.field_out (field_out),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	delimiter_field_splitter_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.byte_in         (byte_in),
		.field_out       (field_out),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.pending_results (pending_results),
		.fail_count      (fail_count)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin : watchdog
		#200_000_000;
		$display("delimiter_field_splitter_top regression: fail");
		$finish;
	end

	// Result side: stall on a pattern of its own, with one long hold on request
	initial begin : result_sink
		int unsigned span;
		field_out.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				field_out.ready <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
			end else begin
				span = $urandom_range(1, 12);
				case ($urandom_range(0, 5))
					0: field_out.ready <= 1'b0;
					1: begin
						field_out.ready <= 1'b1;
						span = span * 4;
					end
					default: field_out.ready <= ($urandom_range(0, 2) != 0);
				endcase
				repeat (span) @(posedge clk);
			end
		end
	end

	task automatic push_byte(input logic [7:0] b, input logic last);
		in_item_t item;
		item.data_byte = b;
		item.last_byte = last;
		stim_q.push_back(item);
	endtask

	function automatic logic [7:0] blank_char();
		return ($urandom_range(0, 1) != 0) ? CHAR_SPACE : CHAR_TAB;
	endfunction

	// Field content: letters, blanks, delimiter characters and raw bytes
	function automatic logic [7:0] pick_char();
		int unsigned k;
		k = $urandom_range(0, cur_len - 1);
		case ($urandom_range(0, 9))
			0, 1:    return blank_char();
			2, 3:    return cur_delim[8*k +: 8];
			4:       return 8'($urandom);
			default: return 8'h61 + 8'($urandom_range(0, 25));
		endcase
	endfunction

	// One buffer: mostly delimited fields with padding, sometimes raw noise
	task automatic add_buffer();
		int unsigned nf;
		int unsigned f;
		int unsigned k;
		int unsigned start_size;
		start_size = stim_q.size();
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 12)) push_byte(8'($urandom), 1'b0);
		end else begin
			nf = $urandom_range(1, 5);
			for (f = 0; f < nf; f++) begin
				repeat ($urandom_range(0, 2)) push_byte(blank_char(), 1'b0);
				repeat ($urandom_range(0, 6)) push_byte(pick_char(), 1'b0);
				repeat ($urandom_range(0, 2)) push_byte(blank_char(), 1'b0);
				if ($urandom_range(0, 6) != 0) begin
					for (k = 0; k < cur_len; k++)
						push_byte(cur_delim[8*k +: 8], 1'b0);
				end
			end
			if ($urandom_range(0, 1) == 0)
				repeat ($urandom_range(1, 4)) push_byte(pick_char(), 1'b0);
		end
		if (stim_q.size() == start_size)
			push_byte(pick_char(), 1'b0);
		stim_q[$].last_byte = 1'b1;
	endtask

	// Write all three registers on consecutive edges; the block must be idle
	task automatic load_config(input logic [63:0] delim, input logic [3:0] len_code,
		input logic trim);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_DELIM_BYTES;
		cfg_data  <= delim;
		@(posedge clk);
		cfg_index <= CFG_DELIM_LENGTH;
		cfg_data  <= {$urandom, 28'($urandom), len_code};
		@(posedge clk);
		cfg_index <= CFG_TRIM_ENABLE;
		cfg_data  <= {$urandom, 31'($urandom), trim};
		@(posedge clk);
		cfg_we    <= 1'b0;
		cur_delim = delim;
		if (len_code == 0)
			cur_len = 1;
		else if (len_code > 8)
			cur_len = 8;
		else
			cur_len = len_code;
	endtask

	// Send the queued requests in bursts separated by random gaps
	task automatic drive_stream();
		int unsigned burst_left;
		int unsigned gap;
		burst_left = 0;
		while (stim_q.size() != 0) begin
			if (burst_left == 0) begin
				gap = (no_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				if (gap != 0) begin
					byte_in.valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
				burst_left = $urandom_range(1, 32);
			end
			byte_in.valid     <= 1'b1;
			byte_in.data_byte <= stim_q[0].data_byte;
			byte_in.last_byte <= stim_q[0].last_byte;
			do begin
				@(posedge clk);
			end while (!byte_in.ready);
			void'(stim_q.pop_front());
			burst_left--;
		end
		byte_in.valid <= 1'b0;
	endtask

	// Hold until every predicted result has arrived, then let the pipeline empty
	task automatic wait_drained();
		@(posedge clk);
		while (pending_results != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin : stimulus
		int unsigned ph;
		logic [3:0]  len_code;

		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_index         = '0;
		cfg_data          = '0;
		byte_in.valid     = 1'b0;
		byte_in.data_byte = '0;
		byte_in.last_byte = 1'b0;
		no_gaps           = 1'b0;
		long_hold_req     = 1'b0;
		cur_delim         = 64'd44;
		cur_len           = 1;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: a field, an empty field, extreme bytes, end without match
		push_byte("x", 1'b0);
		push_byte(",", 1'b0);
		push_byte(",", 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'hFF, 1'b1);
		drive_stream();
		wait_drained();

		// Oversized length acts as eight; trim both sides; match on the last byte
		load_config(64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1'b1);
		push_byte(CHAR_SPACE, 1'b0);
		push_byte(CHAR_TAB, 1'b0);
		push_byte("A", 1'b0);
		push_byte(CHAR_SPACE, 1'b0);
		repeat (7) push_byte(8'hFF, 1'b0);
		push_byte(8'hFF, 1'b1);
		drive_stream();
		wait_drained();

		// Zero length acts as one; all-blank field and empty field with trimming
		load_config(64'h0, 4'd0, 1'b1);
		push_byte(CHAR_SPACE, 1'b0);
		push_byte(CHAR_TAB, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'h00, 1'b1);
		drive_stream();
		wait_drained();

		// Change the delimiter in the middle of a field
		load_config(64'h6261, 4'd2, 1'b0);
		push_byte("x", 1'b0);
		push_byte("a", 1'b0);
		drive_stream();
		wait_drained();
		load_config(64'h62, 4'd1, 1'b0);
		push_byte("b", 1'b0);
		push_byte("c", 1'b1);
		drive_stream();
		wait_drained();

		// Random buffers under a new setting per phase
		for (ph = 0; ph < RANDOM_PHASES; ph++) begin
			case (ph)
				0: len_code = 4'd8;
				1: len_code = 4'd1;
				2: len_code = 4'd0;
				3: len_code = 4'd15;
				default: len_code = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(9, 14)) :
					4'($urandom_range(1, 8));
			endcase
			load_config({$urandom, $urandom}, len_code,
				(ph == 0) ? 1'b1 : (ph == 1) ? 1'b0 : 1'($urandom));
			while (stim_q.size() < PHASE_BYTES)
				add_buffer();
			// In the second phase, stream without gaps into a long result stall so the input backs up
			no_gaps = (ph == 1);
			if (ph == 1)
				long_hold_req = 1'b1;
			drive_stream();
			wait_drained();
		end

		if (fail_count == 0)
			$display("delimiter_field_splitter_top regression: pass");
		else
			$display("delimiter_field_splitter_top regression: fail");
		$finish;
	end

endmodule

FILE: files.f
sv/dfs_pkg.sv
sv/dfs_channels.sv
sv/dfs_cfg.sv
sv/dfs_core.sv
sv/delimiter_field_splitter_top.sv
sim/delimiter_field_splitter_checker.sv
sim/delimiter_field_splitter_top_tb.sv
